>>> hw/rtl/ecd_pkg.sv
// Shared widths and pipeline control types for the epoch-to-civil-date converter.
package ecd_pkg;

  // Field widths of the timestamp and of the civil date and time.
  localparam int SECS_W   = 41;
  localparam int YEAR_W   = 17;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Number of register stages between the input and the output transfer.
  localparam int NUM_STAGES = 12;

  // Per-stage load enables and valid flags handed from the control to the datapath.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

>>> hw/rtl/ecd_if.sv
// Valid/ready channel interfaces for timestamps in and civil date and time out.
interface ecd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ecd_pkg::SECS_W-1:0]  epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ecd_pkg::YEAR_W-1:0]  year;
  logic [ecd_pkg::MONTH_W-1:0]        month;
  logic [ecd_pkg::DAY_W-1:0]          day;
  logic [ecd_pkg::HOUR_W-1:0]         hour;
  logic [ecd_pkg::MINUTE_W-1:0]       minute;
  logic [ecd_pkg::SECOND_W-1:0]       second;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, input ready);
  modport sink (input valid, input year, input month, input day, input hour,
                input minute, input second, output ready);
endinterface

>>> hw/rtl/ecd_pipe_ctrl.sv
// Valid tracking and per-stage load enables for the conversion pipeline.
module ecd_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               upstream_valid,
  input  logic               downstream_ready,
  output ecd_pkg::pipe_ctrl_t ctrl
);
  import ecd_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES-1:0] load;

  // A stage loads when it is empty or when its content moves on, so bubbles close up.
  always_comb begin
    load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || downstream_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  // Loading stages take the flag of their predecessor; the others hold.
  assign valid_next = (load & {valid[NUM_STAGES-2:0], upstream_valid}) | (~load & valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign ctrl = '{load: load, valid: valid};

endmodule

>>> hw/rtl/epoch_seconds_to_civil_datetime.sv
// Top level: signed epoch seconds to proleptic Gregorian date and UTC time of day.
//
// A timestamp arrives on the stamp channel (valid/ready, epoch_seconds, 41-bit signed)
// and one result leaves on the civil channel (year, month, day, hour, minute, second).
// The conversion is a twelve-stage pipeline that takes one transfer per clock cycle
// while civil is not stalled. The input is registered at the transfer edge, and the
// result is held in the last stage until its output transfer. In the stage chain, the
// day split by 86400 (reciprocal multiply plus one correction step), the 400-year era
// split, the year-of-era division and the month lookup by multiplication each take
// their own register stages.
// Every stage holds while its successor is full and blocked; empty stages keep filling,
// so a stall on civil fills the pipeline first and only then drops stamp.ready.
// Nothing is lost or repeated across a stall, and the payload on civil holds still.
// Reset (rst, synchronous) empties the pipeline; the data registers are not cleared.
// The block keeps no state between items.
module epoch_seconds_to_civil_datetime (
  input logic       clk,
  input logic       rst,
  ecd_in_if.sink    stamp,
  ecd_out_if.source civil
);
  import ecd_pkg::*;

  // Bias that makes the seconds count nonnegative; a whole number of days.
  localparam logic [41:0] SecsBias   = 42'd1099511712000;
  // 86400 is 128 times 675: the low seven bits pass by the division.
  localparam logic [25:0] DayRecip   = 26'((64'd1 << 35) / 64'd675);
  localparam logic [9:0]  DayOdd     = 10'd675;
  // Day bias: undoes the seconds bias, adds the March shift and 83 whole eras.
  localparam logic [24:0] DayBias    = 25'd119689;
  localparam logic [25:0] EraRecip   = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [17:0] DaysPerEra = 18'd146097;
  localparam logic [17:0] EraLastDay = 18'd146096;
  localparam logic [17:0] HourRecip  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [17:0] MinRecip   = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
  localparam logic [18:0] Recip1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] Recip36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] Recip365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  Recip100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] Recip153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] Recip5     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam logic [17:0] YearBias   = 18'd33200;
  localparam logic [3:0]  FirstJanMp = 4'd10;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

  pipe_ctrl_t ctrl;

  ecd_pipe_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .upstream_valid   (stamp.valid),
    .downstream_ready (civil.ready),
    .ctrl             (ctrl)
  );

  assign stamp.ready = ctrl.load[0];
  assign civil.valid = ctrl.valid[NUM_STAGES-1];

  // Stage 0: sign-extend and bias the seconds count.
  logic [41:0] s0_u;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s0_u <= {stamp.epoch_seconds[SECS_W-1], stamp.epoch_seconds} + SecsBias;
    end
  end

  // Stage 1: quotient estimate by 675, at most one low.
  logic [60:0] day_prod;
  logic [34:0] s1_v;
  logic [6:0]  s1_lo;
  logic [25:0] s1_qe;

  assign day_prod = 61'(s0_u[41:7]) * 61'(DayRecip);

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s1_v  <= s0_u[41:7];
      s1_lo <= s0_u[6:0];
      s1_qe <= day_prod[60:35];
    end
  end

  // Stage 2: remainder of the estimate, below twice 675.
  logic [34:0] day_back;
  logic [34:0] day_rem0;
  logic [25:0] s2_qe;
  logic [6:0]  s2_lo;
  logic [10:0] s2_r0;

  assign day_back = 35'(s1_qe) * 35'(DayOdd);
  assign day_rem0 = s1_v - day_back;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s2_qe <= s1_qe;
      s2_lo <= s1_lo;
      s2_r0 <= day_rem0[10:0];
    end
  end

  // Stage 3: correct the quotient, form the shifted day number and seconds of day.
  logic        day_carry;
  logic [10:0] day_rem;
  logic [24:0] s3_z;
  logic [16:0] s3_rem;

  assign day_carry = (s2_r0 >= 11'(DayOdd));
  assign day_rem   = s2_r0 - (day_carry ? 11'(DayOdd) : 11'd0);

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s3_z   <= 25'(s2_qe) + 25'(day_carry) + DayBias;
      s3_rem <= {day_rem[9:0], s2_lo};
    end
  end

  // Stage 4: era index, hours and total minutes.
  logic [50:0] era_prod;
  logic [34:0] hour_prod;
  logic [34:0] min_prod;
  logic [24:0] s4_z;
  logic [16:0] s4_rem;
  logic [7:0]  s4_era;
  logic [4:0]  s4_hour;
  logic [10:0] s4_mins;

  assign era_prod  = 51'(s3_z) * 51'(EraRecip);
  assign hour_prod = 35'(s3_rem) * 35'(HourRecip);
  assign min_prod  = 35'(s3_rem) * 35'(MinRecip);

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s4_z    <= s3_z;
      s4_rem  <= s3_rem;
      s4_era  <= era_prod[50:43];
      s4_hour <= hour_prod[33:29];
      s4_mins <= min_prod[33:23];
    end
  end

  // Stage 5: day of era, and minute and second by back-multiplication.
  logic [24:0] era_back;
  logic [24:0] doe_full;
  logic [16:0] mins_back;
  logic [16:0] sec_full;
  logic [10:0] hour_back;
  logic [10:0] min_full;
  logic [17:0] s5_doe;
  logic [7:0]  s5_era;
  tod_t        s5_tod;

  assign era_back  = 25'(s4_era) * 25'(DaysPerEra);
  assign doe_full  = s4_z - era_back;
  assign mins_back = 17'(s4_mins) * 17'd60;
  assign sec_full  = s4_rem - mins_back;
  assign hour_back = 11'(s4_hour) * 11'd60;
  assign min_full  = s4_mins - hour_back;

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s5_doe <= doe_full[17:0];
      s5_era <= s4_era;
      s5_tod <= '{hour: s4_hour, minute: min_full[5:0], second: sec_full[5:0]};
    end
  end

  // Stage 6: leap corrections of the day of era.
  logic [36:0] q1460_prod;
  logic [36:0] q36524_prod;
  logic [17:0] s6_doe;
  logic [7:0]  s6_era;
  logic [6:0]  s6_a;
  logic [2:0]  s6_b;
  logic        s6_c;
  tod_t        s6_tod;

  assign q1460_prod  = 37'(s5_doe) * 37'(Recip1460);
  assign q36524_prod = 37'(s5_doe) * 37'(Recip36524);

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      s6_doe <= s5_doe;
      s6_era <= s5_era;
      s6_a   <= q1460_prod[35:29];
      s6_b   <= q36524_prod[36:34];
      s6_c   <= (s5_doe == EraLastDay);
      s6_tod <= s5_tod;
    end
  end

  // Stage 7: day count with the leap days taken out.
  logic [17:0] s7_t;
  logic [17:0] s7_doe;
  logic [7:0]  s7_era;
  tod_t        s7_tod;

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      s7_t   <= s6_doe - 18'(s6_a) + 18'(s6_b) - 18'(s6_c);
      s7_doe <= s6_doe;
      s7_era <= s6_era;
      s7_tod <= s6_tod;
    end
  end

  // Stage 8: year of era.
  logic [36:0] yoe_prod;
  logic [8:0]  s8_yoe;
  logic [17:0] s8_doe;
  logic [7:0]  s8_era;
  tod_t        s8_tod;

  assign yoe_prod = 37'(s7_t) * 37'(Recip365);

  always_ff @(posedge clk) begin
    if (ctrl.load[8]) begin
      s8_yoe <= yoe_prod[35:27];
      s8_doe <= s7_doe;
      s8_era <= s7_era;
      s8_tod <= s7_tod;
    end
  end

  // Stage 9: day of the March-based year and the March-based calendar year.
  logic [18:0] cent_prod;
  logic [17:0] year_days;
  logic [17:0] doy_full;
  logic [17:0] year_base;
  logic [8:0]  s9_doy;
  logic [16:0] s9_year;
  tod_t        s9_tod;

  assign cent_prod = 19'(s8_yoe) * 19'(Recip100);
  assign year_days = 18'(s8_yoe) * 18'd365 + 18'(s8_yoe[8:2]) - 18'(cent_prod[17:16]);
  assign doy_full  = s8_doe - year_days;
  assign year_base = 18'(s8_yoe) + 18'(s8_era) * 18'd400 - YearBias;

  always_ff @(posedge clk) begin
    if (ctrl.load[9]) begin
      s9_doy  <= doy_full[8:0];
      s9_year <= year_base[16:0];
      s9_tod  <= s8_tod;
    end
  end

  // Stage 10: month index counted from March.
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [3:0]  s10_mp;
  logic [8:0]  s10_doy;
  logic [16:0] s10_year;
  tod_t        s10_tod;

  assign mp_num  = 11'(s9_doy) * 11'd5 + 11'd2;
  assign mp_prod = 23'(mp_num) * 23'(Recip153);

  always_ff @(posedge clk) begin
    if (ctrl.load[10]) begin
      s10_mp   <= mp_prod[22:19];
      s10_doy  <= s9_doy;
      s10_year <= s9_year;
      s10_tod  <= s9_tod;
    end
  end

  // Stage 11: day of month, January-based month and the year bump for January and
  // February, into the output register.
  logic [10:0] md_num;
  logic [22:0] md_prod;
  logic [8:0]  day_full;
  logic        jan_feb;

  assign md_num   = 11'(s10_mp) * 11'd153 + 11'd2;
  assign md_prod  = 23'(md_num) * 23'(Recip5);
  assign day_full = s10_doy - md_prod[22:14] + 9'd1;
  assign jan_feb  = (s10_mp >= FirstJanMp);

  always_ff @(posedge clk) begin
    if (ctrl.load[11]) begin
      civil.year   <= $signed(s10_year + 17'(jan_feb));
      civil.month  <= jan_feb ? (s10_mp - 4'd9) : (s10_mp + 4'd3);
      civil.day    <= day_full[4:0];
      civil.hour   <= s10_tod.hour;
      civil.minute <= s10_tod.minute;
      civil.second <= s10_tod.second;
    end
  end

endmodule

>>> hw/rtl/ecd_checker.sv
// Port-level assertions for the epoch-to-civil-date converter, bound to its top level.
module ecd_checker (
  input logic       clk,
  input logic       rst,
  ecd_in_if.sink    stamp,
  ecd_out_if.source civil
);

  // Reset empties the pipeline, so no result is offered right after it.
  a_reset_empties: assert property (@(posedge clk) rst |=> !civil.valid)
    else $error("result offered right after reset");

  // When the output is free, the pipeline can always advance and take a timestamp.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!civil.valid || civil.ready) |-> stamp.ready)
    else $error("input blocked although the output can move");

  // Every offered result is a well-formed date and time of day.
  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    civil.valid |-> (civil.month >= 4'd1) && (civil.month <= 4'd12) &&
                    (civil.day >= 5'd1) && (civil.day <= 5'd31) &&
                    (civil.hour <= 5'd23) && (civil.minute <= 6'd59) &&
                    (civil.second <= 6'd59))
    else $error("result field out of calendar range");

  // A stalled result stays offered and unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    civil.valid && !civil.ready |=> civil.valid && $stable(civil.year) &&
      $stable(civil.month) && $stable(civil.day) && $stable(civil.hour) &&
      $stable(civil.minute) && $stable(civil.second))
    else $error("stalled result changed or dropped");

endmodule

bind epoch_seconds_to_civil_datetime ecd_checker u_ecd_checker (
  .clk   (clk),
  .rst   (rst),
  .stamp (stamp),
  .civil (civil)
);

>>> bench/tb_epoch_seconds_to_civil_datetime.sv
// Self-checking testbench for the epoch seconds to civil date and time converter.
module tb_epoch_seconds_to_civil_datetime;
  import ecd_pkg::*;

  localparam int     IDLE_LIMIT   = 4000;
  localparam int     DRAIN_CYCLES = 2 * NUM_STAGES;
  localparam int     MAX_REPORTS  = 10;
  localparam longint DAY_SECS     = 86400;
  localparam longint EPOCH_SHIFT  = 719468;
  localparam longint ERA_DAYS     = 146097;
  localparam longint STAMP_MAX    = 64'sd1099511627775;
  localparam longint STAMP_MIN    = -64'sd1099511627776;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic [MINUTE_W-1:0]      minute;
    logic [SECOND_W-1:0]      second;
  } civil_t;

  logic clk;
  logic rst;
  bit   quiet;
  int   mismatches = 0;
  int   idle_cycles = 0;

  civil_t pending_dates[$];

  ecd_in_if  stamp ();
  ecd_out_if civil ();

  epoch_seconds_to_civil_datetime uut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp),
    .civil (civil)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Division rounded toward minus infinity.
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // Expected civil date and time for one timestamp, by the 400-year era method.
  function automatic civil_t civil_from_stamp(input logic signed [SECS_W-1:0] stamp_secs);
    longint secs, days, sod, era, doe, yoe, yr, doy, mp, dom, mon, hr, mi, sc;
    civil_t r;
    secs = longint'(stamp_secs);
    days = floor_div(secs, DAY_SECS);
    sod  = secs - days * DAY_SECS;
    days = days + EPOCH_SHIFT;
    era  = floor_div(days, ERA_DAYS);
    doe  = days - era * ERA_DAYS;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr   = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dom  = doy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    // January and February belong to the next civil year.
    if (mon <= 2) yr = yr + 1;
    hr   = sod / 3600;
    mi   = (sod / 60) % 60;
    sc   = sod % 60;
    r.year   = yr[YEAR_W-1:0];
    r.month  = mon[MONTH_W-1:0];
    r.day    = dom[DAY_W-1:0];
    r.hour   = hr[HOUR_W-1:0];
    r.minute = mi[MINUTE_W-1:0];
    r.second = sc[SECOND_W-1:0];
    return r;
  endfunction

  // Random timestamp: full range, near the epoch, near midnight, or near an era start.
  function automatic longint random_stamp();
    longint days;
    case ($urandom_range(0, 3))
      0: return longint'({$urandom, $urandom});
      1: return longint'($urandom_range(0, 32'hFFFF_FFFF)) - 64'sd2147483648;
      2: begin
        days = longint'($urandom_range(0, 25000000)) - 12500000;
        return days * DAY_SECS + longint'($urandom_range(0, 4)) - 2;
      end
      default: begin
        days = (longint'($urandom_range(0, 160)) - 80) * ERA_DAYS - EPOCH_SHIFT;
        days = days + longint'($urandom_range(0, 800)) - 400;
        return days * DAY_SECS + longint'($urandom_range(0, 172800)) - DAY_SECS;
      end
    endcase
  endfunction

  // Present one timestamp, after an optional gap, and hold it until ready is seen high.
  task automatic send_stamp(input longint value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      stamp.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    stamp.valid         <= 1'b1;
    stamp.epoch_seconds <= value[SECS_W-1:0];
    @(posedge clk);
    while (!stamp.ready) @(posedge clk);
  endtask

  // The epoch itself, its neighbors, the edges of a day on either side and the 32-bit limits.
  task automatic test_epoch_neighborhood();
    send_stamp(0);
    send_stamp(1);
    send_stamp(-1);
    send_stamp(DAY_SECS - 1);
    send_stamp(DAY_SECS);
    send_stamp(-DAY_SECS);
    send_stamp(-DAY_SECS - 1);
    send_stamp(64'sd2147483647);
    send_stamp(64'sd2147483648);
    send_stamp(64'sd4294967295);
  endtask

  // Leap days, a century that is not a leap year, and the start of year zero.
  task automatic test_leap_rules();
    send_stamp(64'sd951782399);
    send_stamp(64'sd951782400);
    send_stamp(64'sd951868800);
    send_stamp(-64'sd2208988800);
    send_stamp(-64'sd2203891201);
    send_stamp(-64'sd2203891200);
    send_stamp(-64'sd62167219200);
    send_stamp(-64'sd62167219201);
    send_stamp(-64'sd62172403200);
    send_stamp(-64'sd62172403201);
    send_stamp(64'sd253402300799);
  endtask

  // The most positive and most negative timestamps and their neighbors.
  task automatic test_range_limits();
    send_stamp(STAMP_MAX);
    send_stamp(STAMP_MAX - 1);
    send_stamp(STAMP_MIN);
    send_stamp(STAMP_MIN + 1);
  endtask

  // Random timestamps under random gaps and stalls.
  task automatic test_random_stamps(input int count);
    repeat (count) send_stamp(random_stamp());
  endtask

  // Random timestamps at full rate with the output never stalled.
  task automatic test_streaming(input int count);
    quiet = 1'b1;
    repeat (count) send_stamp(random_stamp());
  endtask

  // Output ready toggles in random bursts, and stays high once the run goes quiet.
  initial begin
    int run;
    run = 0;
    civil.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        civil.ready <= 1'b0;
      end else if (quiet) begin
        civil.ready <= 1'b1;
      end else if (run == 0) begin
        civil.ready <= ($urandom_range(0, 2) != 0);
        run = $urandom_range(1, 12);
      end else begin
        run = run - 1;
      end
    end
  end

  // Record the expected date at each input transfer and check each output transfer.
  always @(posedge clk) begin
    civil_t got, want;
    if (!rst) begin
      if (stamp.valid && stamp.ready)
        pending_dates.push_back(civil_from_stamp(stamp.epoch_seconds));
      if (civil.valid && civil.ready) begin
        got = '{civil.year, civil.month, civil.day, civil.hour, civil.minute, civil.second};
        if (pending_dates.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                     got.day, got.hour, got.minute, got.second);
        end else begin
          want = pending_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.hour !== want.hour || got.minute !== want.minute ||
              got.second !== want.second) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                       want.year, want.month, want.day, want.hour, want.minute, want.second,
                       got.year, got.month, got.day, got.hour, got.minute, got.second);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((stamp.valid && stamp.ready) || (civil.valid && civil.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_epoch_seconds_to_civil_datetime NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    quiet               = 1'b0;
    rst                 = 1'b1;
    stamp.valid         = 1'b0;
    stamp.epoch_seconds = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_epoch_neighborhood();
    test_leap_rules();
    test_range_limits();
    test_random_stamps(1175);
    test_streaming(150);
    stamp.valid <= 1'b0;

    // Drain the pipeline, then keep watching for stray results.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_epoch_seconds_to_civil_datetime OK");
    end else begin
      $display("tb_epoch_seconds_to_civil_datetime NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ecd_pkg.sv
hw/rtl/ecd_if.sv
hw/rtl/ecd_pipe_ctrl.sv
hw/rtl/epoch_seconds_to_civil_datetime.sv
hw/rtl/ecd_checker.sv
bench/tb_epoch_seconds_to_civil_datetime.sv
